// ----- rtl/core/lfpd_pkg.sv -----
package lfpd_pkg;

	// Sample and integrator widths
	localparam int SAMPLE_BITS = 10;
	localparam int SUM_BITS    = 16;

	// Fixed field widths
	localparam int ERR_W   = 4;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int PD_W    = 13;
	localparam int SPEED_W = 9;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_I_Q8   = 3'd3;
	localparam logic [IDX_W-1:0] REG_BASE_SPEED  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SPEED_LIMIT = 3'd5;

	// Configuration reset values
	localparam logic [9:0]  RST_THRESHOLD   = 10'd600;
	localparam logic [7:0]  RST_GAIN_P      = 8'd35;
	localparam logic [7:0]  RST_GAIN_D      = 8'd0;
	localparam logic [15:0] RST_GAIN_I_Q8   = 16'd0;
	localparam logic [7:0]  RST_BASE_SPEED  = 8'd80;
	localparam logic [7:0]  RST_SPEED_LIMIT = 8'd100;

	// Sensor patterns, far left in the top bit, white reads as one
	localparam logic [4:0] PAT_P4 = 5'b11110;
	localparam logic [4:0] PAT_P3 = 5'b11100;
	localparam logic [4:0] PAT_P2 = 5'b11101;
	localparam logic [4:0] PAT_P1 = 5'b11001;
	localparam logic [4:0] PAT_Z0 = 5'b11011;
	localparam logic [4:0] PAT_N1 = 5'b10011;
	localparam logic [4:0] PAT_N2 = 5'b10111;
	localparam logic [4:0] PAT_N3 = 5'b00111;
	localparam logic [4:0] PAT_N4 = 5'b01111;

	// Position error codes
	localparam logic signed [ERR_W-1:0] ERR_P4 = 4'sd4;
	localparam logic signed [ERR_W-1:0] ERR_P3 = 4'sd3;
	localparam logic signed [ERR_W-1:0] ERR_P2 = 4'sd2;
	localparam logic signed [ERR_W-1:0] ERR_P1 = 4'sd1;
	localparam logic signed [ERR_W-1:0] ERR_Z0 = 4'sd0;
	localparam logic signed [ERR_W-1:0] ERR_N1 = -4'sd1;
	localparam logic signed [ERR_W-1:0] ERR_N2 = -4'sd2;
	localparam logic signed [ERR_W-1:0] ERR_N3 = -4'sd3;
	localparam logic signed [ERR_W-1:0] ERR_N4 = -4'sd4;

	// Map a sensor pattern to a position error; keep the previous one otherwise
	function automatic logic signed [ERR_W-1:0] decode_error(
		input logic [4:0]              pat,
		input logic signed [ERR_W-1:0] prev
	);
		logic signed [ERR_W-1:0] e;
		case (pat)
			PAT_P4:  e = ERR_P4;
			PAT_P3:  e = ERR_P3;
			PAT_P2:  e = ERR_P2;
			PAT_P1:  e = ERR_P1;
			PAT_Z0:  e = ERR_Z0;
			PAT_N1:  e = ERR_N1;
			PAT_N2:  e = ERR_N2;
			PAT_N3:  e = ERR_N3;
			PAT_N4:  e = ERR_N4;
			default: e = prev;
		endcase
		return e;
	endfunction

endpackage

// ----- rtl/core/lfpd_in_if.sv -----
interface lfpd_in_if;
	logic                           valid;
	logic                           ready;
	logic [lfpd_pkg::SAMPLE_BITS-1:0] sensor_far_left;
	logic [lfpd_pkg::SAMPLE_BITS-1:0] sensor_left;
	logic [lfpd_pkg::SAMPLE_BITS-1:0] sensor_center;
	logic [lfpd_pkg::SAMPLE_BITS-1:0] sensor_right;
	logic [lfpd_pkg::SAMPLE_BITS-1:0] sensor_far_right;

	modport source (
		output valid, sensor_far_left, sensor_left, sensor_center,
		       sensor_right, sensor_far_right,
		input  ready
	);
	modport sink (
		input  valid, sensor_far_left, sensor_left, sensor_center,
		       sensor_right, sensor_far_right,
		output ready
	);
endinterface

// ----- rtl/core/lfpd_out_if.sv -----
interface lfpd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [lfpd_pkg::SPEED_W-1:0] left_speed;
	logic signed [lfpd_pkg::SPEED_W-1:0] right_speed;
	logic signed [lfpd_pkg::ERR_W-1:0]   position_error;

	modport source (
		output valid, left_speed, right_speed, position_error,
		input  ready
	);
	modport sink (
		input  valid, left_speed, right_speed, position_error,
		output ready
	);
endinterface

// ----- rtl/core/line_follower_pid_drive_core.sv -----
// Five-sensor line follower PID drive. Each sensor word is thresholded into a
// white/black pattern, decoded to a position error (-4..+4, unknown patterns
// and all-white keep the last error), and turned into left and right wheel
// speeds: base +/- (kp*e + kd*(e - e_prev) + trunc(ki_q8*sum/256)), clamped
// to +/- speed_limit. It takes one word per cycle unless a stalled output
// has filled every stage. It has five register stages: the threshold compare,
// the error decode with the integrator update, the ki*sum multiply, the drive
// sum, and the wheel clamp. The first stage loads at the accepting edge; the
// result word leaves from the clamp stage. Every stage has its own valid bit
// and ready, so a stalled output only blocks input once all stages are full.
// Configuration registers are written through cfg_we/cfg_index/cfg_data.
module line_follower_pid_drive_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lfpd_pkg::IDX_W-1:0] cfg_index,
	input  logic [lfpd_pkg::CFG_W-1:0] cfg_data,
	lfpd_in_if.sink                      sensors,
	lfpd_out_if.source                   drive
);
	import lfpd_pkg::*;

	localparam int PROD_W  = SUM_BITS + 17;
	localparam int INT_W   = PROD_W - 8;
	localparam int DRIVE_W = INT_W + 1;
	localparam int WHEEL_W = DRIVE_W + 1;

	localparam logic signed [SUM_BITS:0] SUM_MAX = {2'b00, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS:0] SUM_MIN = {2'b11, {(SUM_BITS-1){1'b0}}};
	localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'(255);

	// Configuration registers
	logic [9:0]  threshold_q;
	logic [7:0]  gain_p_q;
	logic [7:0]  gain_d_q;
	logic [15:0] gain_i_q8_q;
	logic [7:0]  base_speed_q;
	logic [7:0]  speed_limit_q;

	// Controller state
	logic signed [ERR_W-1:0]    last_error_q;
	logic signed [SUM_BITS-1:0] error_sum_q;

	// Stage valids and readies
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// Stage payloads
	logic [4:0]                 pat_s1;
	logic signed [ERR_W-1:0]    err_s2, err_s3, err_s4, err_s5;
	logic signed [DIFF_W-1:0]   diff_s2;
	logic signed [SUM_BITS-1:0] sum_s2;
	logic signed [PD_W-1:0]     pd_s3;
	logic signed [PROD_W-1:0]   prod_s3;
	logic signed [DRIVE_W-1:0]  drive_s4;
	logic signed [SPEED_W-1:0]  left_s5, right_s5;

	// Combinational values
	logic [SAMPLE_BITS-1:0]     thr;
	logic [4:0]                 pat;
	logic signed [ERR_W-1:0]    err;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [SUM_BITS:0]   sum_wide;
	logic signed [SUM_BITS-1:0] sum_next;
	logic signed [PD_W-1:0]     gp_ext, gd_ext, err_ext, diff_ext, p_term, d_term;
	logic signed [PROD_W-1:0]   gi_ext, sum_ext, prod;
	logic signed [PROD_W-1:0]   prod_adj;
	logic signed [INT_W-1:0]    integ;
	logic signed [WHEEL_W-1:0]  base_ext, lim_ext, left_w, right_w;
	logic signed [SPEED_W-1:0]  left_c, right_c;

	// Ready chain: a stage takes a word when empty or when it moves on
	assign rdy5 = !v_s5 || drive.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign sensors.ready = rdy1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= RST_THRESHOLD;
			gain_p_q      <= RST_GAIN_P;
			gain_d_q      <= RST_GAIN_D;
			gain_i_q8_q   <= RST_GAIN_I_Q8;
			base_speed_q  <= RST_BASE_SPEED;
			speed_limit_q <= RST_SPEED_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:   threshold_q   <= cfg_data[9:0];
				REG_GAIN_P:      gain_p_q      <= cfg_data[7:0];
				REG_GAIN_D:      gain_d_q      <= cfg_data[7:0];
				REG_GAIN_I_Q8:   gain_i_q8_q   <= cfg_data[15:0];
				REG_BASE_SPEED:  base_speed_q  <= cfg_data[7:0];
				REG_SPEED_LIMIT: speed_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Threshold the five samples
	always_comb begin
		thr    = SAMPLE_BITS'(threshold_q);
		pat[4] = sensors.sensor_far_left  >= thr;
		pat[3] = sensors.sensor_left      >= thr;
		pat[2] = sensors.sensor_center    >= thr;
		pat[1] = sensors.sensor_right     >= thr;
		pat[0] = sensors.sensor_far_right >= thr;
	end

	// Decode the error and update the integrator
	always_comb begin
		err      = decode_error(pat_s1, last_error_q);
		diff     = DIFF_W'(err) - DIFF_W'(last_error_q);
		sum_wide = (SUM_BITS+1)'(error_sum_q) + (SUM_BITS+1)'(err);
		if (sum_wide > SUM_MAX) begin
			sum_next = SUM_MAX[SUM_BITS-1:0];
		end else if (sum_wide < SUM_MIN) begin
			sum_next = SUM_MIN[SUM_BITS-1:0];
		end else begin
			sum_next = sum_wide[SUM_BITS-1:0];
		end
	end

	// Multiply the gains
	always_comb begin
		gp_ext   = $signed(PD_W'(gain_p_q));
		gd_ext   = $signed(PD_W'(gain_d_q));
		err_ext  = PD_W'(err_s2);
		diff_ext = PD_W'(diff_s2);
		p_term   = gp_ext * err_ext;
		d_term   = gd_ext * diff_ext;
		gi_ext   = $signed(PROD_W'(gain_i_q8_q));
		sum_ext  = PROD_W'(sum_s2);
		prod     = gi_ext * sum_ext;
	end

	// Truncate the integral toward zero and form the drive
	always_comb begin
		prod_adj = prod_s3[PROD_W-1] ? prod_s3 + TRUNC_BIAS : prod_s3;
		integ    = $signed(prod_adj[PROD_W-1:8]);
	end

	// Apply the drive to each wheel and clamp
	always_comb begin
		base_ext = $signed(WHEEL_W'(base_speed_q));
		lim_ext  = $signed(WHEEL_W'(speed_limit_q));
		left_w   = base_ext + WHEEL_W'(drive_s4);
		right_w  = base_ext - WHEEL_W'(drive_s4);
		if (left_w > lim_ext) begin
			left_c = SPEED_W'(lim_ext);
		end else if (left_w < -lim_ext) begin
			left_c = SPEED_W'(-lim_ext);
		end else begin
			left_c = SPEED_W'(left_w);
		end
		if (right_w > lim_ext) begin
			right_c = SPEED_W'(lim_ext);
		end else if (right_w < -lim_ext) begin
			right_c = SPEED_W'(-lim_ext);
		end else begin
			right_c = SPEED_W'(right_w);
		end
	end

	// Advance valid bits and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else begin
			if (rdy1) v_s1 <= sensors.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (v_s1 && rdy2) begin
				last_error_q <= err;
				error_sum_q  <= sum_next;
			end
		end
	end

	// Advance stage payloads
	always_ff @(posedge clk) begin
		if (rdy1 && sensors.valid) begin
			pat_s1 <= pat;
		end
		if (rdy2 && v_s1) begin
			err_s2  <= err;
			diff_s2 <= diff;
			sum_s2  <= error_sum_q;
		end
		if (rdy3 && v_s2) begin
			err_s3  <= err_s2;
			pd_s3   <= p_term + d_term;
			prod_s3 <= prod;
		end
		if (rdy4 && v_s3) begin
			err_s4   <= err_s3;
			drive_s4 <= DRIVE_W'(integ) + DRIVE_W'(pd_s3);
		end
		if (rdy5 && v_s4) begin
			err_s5   <= err_s4;
			left_s5  <= left_c;
			right_s5 <= right_c;
		end
	end

	// Drive the result word
	assign drive.valid          = v_s5;
	assign drive.left_speed     = left_s5;
	assign drive.right_speed    = right_s5;
	assign drive.position_error = err_s5;

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lfpd_pkg::*;

	localparam int IDX_TOP     = (1 << IDX_W) - 1;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	localparam int SUM_MAX     = (1 << (SUM_BITS - 1)) - 1;
	localparam int SUM_MIN     = -SUM_MAX - 1;
	localparam int STALL_MAX   = 6;
	localparam int QUIET_LIMIT = 1000;
	localparam int MIXED_ITEMS = 120;
	localparam int PHASES      = 14;
	localparam int RISE_PHASE  = 5;
	localparam int FALL_PHASE  = 6;
	localparam int RISE_ITEMS  = 120;
	localparam int FALL_ITEMS  = 120;
	localparam int PROBE_COUNT = 15;

	// Patterns outside the decode table
	localparam logic [4:0] PAT_ALL_W = 5'b11111;
	localparam logic [4:0] PAT_ALL_B = 5'b00000;
	localparam logic [4:0] PAT_ODD   = 5'b01010;
	localparam logic [4:0] PAT_GAP   = 5'b10101;

	localparam logic [4:0] LINE_PATS [9] = '{
		PAT_P4, PAT_P3, PAT_P2, PAT_P1, PAT_Z0, PAT_N1, PAT_N2, PAT_N3, PAT_N4
	};

	// Sensor index 4 is far left, matching the pattern bit order
	typedef logic [4:0][SAMPLE_BITS-1:0] sensor_set_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left;
		logic signed [SPEED_W-1:0] right;
		logic signed [ERR_W-1:0]   err;
	} wheels_t;

	typedef struct packed {
		logic    pinned;
		wheels_t want;
	} pin_t;

	typedef struct packed {
		logic [4:0]             pat;
		logic [SAMPLE_BITS-1:0] white;
		logic [SAMPLE_BITS-1:0] black;
		logic                   pinned;
		wheels_t                want;
	} probe_t;

	// Directed words, run at reset settings (kp 35, base 80, limit 100)
	localparam probe_t PROBES [PROBE_COUNT] = '{
		'{PAT_P4,    10'd1023, 10'd0,   1'b1, '{9'sd100, -9'sd60, ERR_P4}},
		'{PAT_ALL_W, 10'd1023, 10'd0,   1'b1, '{9'sd100, -9'sd60, ERR_P4}},
		'{PAT_P3,    10'd1023, 10'd0,   1'b1, '{9'sd100, -9'sd25, ERR_P3}},
		'{PAT_P2,    10'd1023, 10'd0,   1'b1, '{9'sd100, 9'sd10,  ERR_P2}},
		'{PAT_P1,    10'd1023, 10'd0,   1'b1, '{9'sd100, 9'sd45,  ERR_P1}},
		'{PAT_Z0,    10'd600,  10'd599, 1'b1, '{9'sd80,  9'sd80,  ERR_Z0}},
		'{PAT_N1,    10'd1023, 10'd0,   1'b1, '{9'sd45,  9'sd100, ERR_N1}},
		'{PAT_N2,    10'd1023, 10'd0,   1'b1, '{9'sd10,  9'sd100, ERR_N2}},
		'{PAT_N3,    10'd1023, 10'd0,   1'b1, '{-9'sd25, 9'sd100, ERR_N3}},
		'{PAT_GAP,   10'd1023, 10'd0,   1'b1, '{-9'sd25, 9'sd100, ERR_N3}},
		'{PAT_N4,    10'd600,  10'd599, 1'b1, '{-9'sd60, 9'sd100, ERR_N4}},
		'{PAT_ALL_B, 10'd1023, 10'd0,   1'b1, '{-9'sd60, 9'sd100, ERR_N4}},
		'{PAT_P4,    10'd600,  10'd599, 1'b1, '{9'sd100, -9'sd60, ERR_P4}},
		'{PAT_ODD,   10'd1023, 10'd0,   1'b0, '0},
		'{PAT_P2,    10'd600,  10'd599, 1'b0, '0}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	lfpd_in_if  sensor_bus ();
	lfpd_out_if wheel_bus ();

	line_follower_pid_drive_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sensors   (sensor_bus),
		.drive     (wheel_bus)
	);

	// Shadow settings and steering state
	logic [SAMPLE_BITS-1:0]     thr;
	logic [7:0]                 gain_p;
	logic [7:0]                 gain_d;
	logic [15:0]                gain_i;
	logic [7:0]                 base;
	logic [7:0]                 speed_lim;
	logic signed [ERR_W-1:0]    last_err;
	logic signed [SUM_BITS-1:0] err_sum;

	pin_t    pin_q [$];
	wheels_t wheel_q [$];
	int      mismatches;
	bit      calm_in;
	bit      calm_out;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic flag_mismatch(string what, int got, int want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Threshold, decode, PID drive and clamp for one word; advance the state
	function automatic wheels_t predict_wheels(sensor_set_t s);
		logic [4:0] pat;
		int         i;
		int         e;
		int         prev;
		int         integ;
		int         push;
		int         lim;
		int         lft;
		int         rgt;
		int         acc;
		wheels_t    w;
		for (i = 0; i < 5; i++)
			pat[i] = (s[i] >= thr);
		prev = last_err;
		case (pat)
			PAT_P4:  e = ERR_P4;
			PAT_P3:  e = ERR_P3;
			PAT_P2:  e = ERR_P2;
			PAT_P1:  e = ERR_P1;
			PAT_Z0:  e = ERR_Z0;
			PAT_N1:  e = ERR_N1;
			PAT_N2:  e = ERR_N2;
			PAT_N3:  e = ERR_N3;
			PAT_N4:  e = ERR_N4;
			default: e = prev;
		endcase
		// Integral uses the sum from before this word, truncated toward zero
		integ = int'((longint'(gain_i) * longint'(err_sum)) / 256);
		push  = int'(gain_p) * e + int'(gain_d) * (e - prev) + integ;
		lim   = int'(speed_lim);
		lft   = int'(base) + push;
		rgt   = int'(base) - push;
		if (lft > lim) lft = lim;
		if (lft < -lim) lft = -lim;
		if (rgt > lim) rgt = lim;
		if (rgt < -lim) rgt = -lim;
		acc = int'(err_sum) + e;
		if (acc > SUM_MAX) acc = SUM_MAX;
		if (acc < SUM_MIN) acc = SUM_MIN;
		err_sum  = SUM_BITS'(acc);
		last_err = ERR_W'(e);
		w.left  = SPEED_W'(lft);
		w.right = SPEED_W'(rgt);
		w.err   = ERR_W'(e);
		return w;
	endfunction

	// Draw samples on the right side of the threshold for each pattern bit
	function automatic sensor_set_t draw_shaped(logic [4:0] pat);
		sensor_set_t s;
		int          i;
		for (i = 0; i < 5; i++) begin
			if (pat[i] || thr == '0)
				s[i] = SAMPLE_BITS'($urandom_range(int'(thr), SAMPLE_MAX));
			else
				s[i] = SAMPLE_BITS'($urandom_range(0, int'(thr) - 1));
		end
		return s;
	endfunction

	// Mostly clean line patterns, then single-bit breaks, blank rows and noise
	function automatic sensor_set_t draw_item();
		logic [4:0]  pat;
		sensor_set_t s;
		int          roll;
		int          i;
		roll = $urandom_range(0, 99);
		pat  = LINE_PATS[$urandom_range(0, 8)];
		if (roll < 60) begin
			s = draw_shaped(pat);
		end else if (roll < 75) begin
			pat[$urandom_range(0, 4)] ^= 1'b1;
			s = draw_shaped(pat);
		end else if (roll < 85) begin
			s = draw_shaped($urandom_range(0, 1) ? PAT_ALL_W : PAT_ALL_B);
		end else begin
			for (i = 0; i < 5; i++)
				s[i] = SAMPLE_BITS'($urandom);
		end
		return s;
	endfunction

	// Zero, all ones, small or random, with junk above the register width
	function automatic logic [CFG_W-1:0] pick_reg(int width);
		logic [CFG_W-1:0] v;
		logic [CFG_W-1:0] mask;
		mask = CFG_W'((1 << width) - 1);
		case ($urandom_range(0, 3))
			0:       v = '0;
			1:       v = mask;
			2:       v = CFG_W'($urandom_range(0, 15));
			default: v = CFG_W'($urandom);
		endcase
		return (CFG_W'($urandom) & ~mask) | (v & mask);
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD:   thr       = data[SAMPLE_BITS-1:0];
			REG_GAIN_P:      gain_p    = data[7:0];
			REG_GAIN_D:      gain_d    = data[7:0];
			REG_GAIN_I_Q8:   gain_i    = data[15:0];
			REG_BASE_SPEED:  base      = data[7:0];
			REG_SPEED_LIMIT: speed_lim = data[7:0];
			default:         ;
		endcase
	endtask

	// Rewrite every register, then poke one unused index
	task automatic load_settings(bit need_black);
		logic [CFG_W-1:0] level;
		level = pick_reg(SAMPLE_BITS);
		if (need_black && level[SAMPLE_BITS-1:0] == '0)
			level[0] = 1'b1;
		write_reg(REG_THRESHOLD, level);
		write_reg(REG_GAIN_P, pick_reg(8));
		write_reg(REG_GAIN_D, pick_reg(8));
		write_reg(REG_GAIN_I_Q8, pick_reg(16));
		write_reg(REG_BASE_SPEED, pick_reg(8));
		write_reg(REG_SPEED_LIMIT, pick_reg(8));
		write_reg(IDX_W'($urandom_range(int'(REG_SPEED_LIMIT) + 1, IDX_TOP)), CFG_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Hold valid across back-to-back words; drop it only for a gap
	task automatic send_sensors(sensor_set_t s, pin_t pin);
		int gap;
		gap = calm_in ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			sensor_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pin_q.push_back(pin);
		sensor_bus.valid            <= 1'b1;
		sensor_bus.sensor_far_left  <= s[4];
		sensor_bus.sensor_left      <= s[3];
		sensor_bus.sensor_center    <= s[2];
		sensor_bus.sensor_right     <= s[1];
		sensor_bus.sensor_far_right <= s[0];
		do @(posedge clk); while (!sensor_bus.ready);
	endtask

	// Predict each accepted sensor word
	always @(posedge clk) begin : predict_on_accept
		sensor_set_t seen;
		pin_t        pin;
		wheels_t     model;
		if (arst_n && sensor_bus.valid && sensor_bus.ready) begin
			seen = {sensor_bus.sensor_far_left, sensor_bus.sensor_left,
			        sensor_bus.sensor_center, sensor_bus.sensor_right,
			        sensor_bus.sensor_far_right};
			model = predict_wheels(seen);
			pin   = pin_q.pop_front();
			wheel_q.push_back(pin.pinned ? pin.want : model);
		end
	end

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin : check_wheels
		wheels_t want;
		if (arst_n && wheel_bus.valid && wheel_bus.ready) begin
			if (wheel_q.size() == 0) begin
				flag_mismatch("left_speed with nothing pending", int'(wheel_bus.left_speed), 0);
			end else begin
				want = wheel_q.pop_front();
				if (wheel_bus.left_speed !== want.left)
					flag_mismatch("left_speed", int'(wheel_bus.left_speed), int'(want.left));
				if (wheel_bus.right_speed !== want.right)
					flag_mismatch("right_speed", int'(wheel_bus.right_speed), int'(want.right));
				if (wheel_bus.position_error !== want.err)
					flag_mismatch("position_error", int'(wheel_bus.position_error),
					              int'(want.err));
			end
		end
	end

	// Stall the result side for a random count before each word
	initial begin
		int stall;
		wheel_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm_out ? 0 : $urandom_range(0, STALL_MAX);
			if (stall > 0) begin
				wheel_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			wheel_bus.ready <= 1'b1;
			do @(posedge clk); while (!wheel_bus.valid);
		end
	end

	// End the run when no word moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sensor_bus.valid && sensor_bus.ready) || (wheel_bus.valid && wheel_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int          n;
		int          i;
		int          ph;
		int          items;
		probe_t      p;
		sensor_set_t s;
		pin_t        pin;

		arst_n                      = 1'b0;
		cfg_we                      = 1'b0;
		cfg_index                   = '0;
		cfg_data                    = '0;
		sensor_bus.valid            = 1'b0;
		sensor_bus.sensor_far_left  = '0;
		sensor_bus.sensor_left      = '0;
		sensor_bus.sensor_center    = '0;
		sensor_bus.sensor_right     = '0;
		sensor_bus.sensor_far_right = '0;
		calm_in                     = 1'b0;
		calm_out                    = 1'b0;
		mismatches                  = 0;
		thr                         = RST_THRESHOLD;
		gain_p                      = RST_GAIN_P;
		gain_d                      = RST_GAIN_D;
		gain_i                      = RST_GAIN_I_Q8;
		base                        = RST_BASE_SPEED;
		speed_lim                   = RST_SPEED_LIMIT;
		last_err                    = '0;
		err_sum                     = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table at reset settings
		for (n = 0; n < PROBE_COUNT; n++) begin
			p = PROBES[n];
			for (i = 0; i < 5; i++)
				s[i] = p.pat[i] ? p.white : p.black;
			pin.pinned = p.pinned;
			pin.want   = p.want;
			send_sensors(s, pin);
		end
		sensor_bus.valid <= 1'b0;

		// Random phases; two one-sided runs push the error sum up, then back down
		for (ph = 0; ph < PHASES; ph++) begin
			@(posedge clk);
			while (wheel_q.size() != 0) @(posedge clk);
			if (ph == RISE_PHASE || ph == FALL_PHASE) begin
				load_settings(1'b1);
				calm_in  = 1'b1;
				calm_out = 1'b1;
				items    = (ph == RISE_PHASE) ? RISE_ITEMS : FALL_ITEMS;
				repeat (items)
					send_sensors(draw_shaped(ph == RISE_PHASE ? PAT_P4 : PAT_N4), '0);
			end else begin
				load_settings(1'b0);
				calm_in  = ($urandom_range(0, 3) == 0);
				calm_out = ($urandom_range(0, 3) == 0);
				repeat (MIXED_ITEMS)
					send_sensors(draw_item(), '0);
			end
			sensor_bus.valid <= 1'b0;
		end

		// Drain, then keep watching the output for stray results
		@(posedge clk);
		while (wheel_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
